/* hw/rtl/scgu_pkg.sv */
// shared types, widths, register indexes and codes of the stochastic cell grid update
// no dependencies; used by every module of the block by scoped names
package scgu_pkg;

   // grid geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM    = 2;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
   localparam int Y_W        = $clog2(MAX_HEIGHT);

   // configuration register widths
   localparam int FW_W   = 9;
   localparam int FH_W   = 13;
   localparam int PROB_W = 14;

   // payload widths
   localparam int STATE_W      = 2;
   localparam int DRAW_W       = 14;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 24;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 14;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_DEATH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_SPONT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PROB_SPREAD  = 3'd4;

   // register reset values
   localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 9'd256;
   localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 13'd256;
   localparam logic [PROB_W-1:0] RST_PROB_DEATH   = 14'd500;
   localparam logic [PROB_W-1:0] RST_PROB_SPONT   = 14'd0;
   localparam logic [PROB_W-1:0] RST_PROB_SPREAD  = 14'd5000;

   // item kinds
   localparam logic REQ_GRID = 1'b0;
   localparam logic REQ_PAD  = 1'b1;

   // cell state codes
   localparam logic [STATE_W-1:0] CELL_INACTIVE = 2'd0;
   localparam logic [STATE_W-1:0] CELL_SPIN_A   = 2'd1;
   localparam logic [STATE_W-1:0] CELL_SPIN_B   = 2'd2;
   localparam logic [STATE_W-1:0] CELL_BAD      = 2'd3;

   typedef logic [STATE_W-1:0] cell_type;

   // line buffer read window around the column in work
   typedef struct packed {
      cell_type above_x;
      cell_type above_xm1;
      cell_type cur_x;
      cell_type cur_xp1;
   } lb_rd_type;

   // cell and its four neighbors with in-grid flags
   typedef struct packed {
      cell_type cur;
      cell_type up;
      cell_type west;
      cell_type east;
      cell_type down;
      logic     has_up;
      logic     has_west;
      logic     has_east;
      logic     has_down;
   } nbr_type;

   // thresholds and random inputs of one update
   typedef struct packed {
      logic [PROB_W-1:0] prob_death;
      logic [PROB_W-1:0] prob_spont;
      logic [PROB_W-1:0] prob_spread;
      logic [DRAW_W-1:0] draw_first;
      logic [DRAW_W-1:0] draw_second;
      logic              spin_pick;
   } rnd_type;

endpackage

/* hw/rtl/scgu_line_buf.sv */
// two line buffers (row above, current row) with registered reads and write forwarding
// depends on scgu_pkg
module scgu_line_buf (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [scgu_pkg::COL_W-1:0] wr_addr,
   input  scgu_pkg::cell_type         above_wdata,
   input  scgu_pkg::cell_type         cur_wdata,
   input  logic [scgu_pkg::COL_W-1:0] rd_addr,
   output scgu_pkg::lb_rd_type        rd_data
);

   scgu_pkg::cell_type above_mem_ff [scgu_pkg::MAX_WIDTH];
   scgu_pkg::cell_type cur_mem_ff   [scgu_pkg::MAX_WIDTH];

   logic [scgu_pkg::COL_W-1:0] rd_west;
   logic [scgu_pkg::COL_W-1:0] rd_east;
   scgu_pkg::lb_rd_type        raw_ff;
   // bit 3 above_x, 2 above_xm1, 1 cur_x, 0 cur_xp1
   logic [3:0]                 fwd_in;
   logic [3:0]                 fwd_ff;
   scgu_pkg::cell_type         above_wr_ff;
   scgu_pkg::cell_type         cur_wr_ff;

   assign rd_west = rd_addr - scgu_pkg::COL_W'(1);
   assign rd_east = rd_addr + scgu_pkg::COL_W'(1);

   assign fwd_in[3] = wr_en && (wr_addr == rd_addr);
   assign fwd_in[2] = wr_en && (wr_addr == rd_west);
   assign fwd_in[1] = wr_en && (wr_addr == rd_addr);
   assign fwd_in[0] = wr_en && (wr_addr == rd_east);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         above_mem_ff[wr_addr] <= above_wdata;
         cur_mem_ff[wr_addr]   <= cur_wdata;
      end
      raw_ff.above_x   <= above_mem_ff[rd_addr];
      raw_ff.above_xm1 <= above_mem_ff[rd_west];
      raw_ff.cur_x     <= cur_mem_ff[rd_addr];
      raw_ff.cur_xp1   <= cur_mem_ff[rd_east];
      fwd_ff           <= fwd_in;
      above_wr_ff      <= above_wdata;
      cur_wr_ff        <= cur_wdata;
   end

   // same-cycle write wins over the old array contents
   always_comb begin
      rd_data.above_x   = fwd_ff[3] ? above_wr_ff : raw_ff.above_x;
      rd_data.above_xm1 = fwd_ff[2] ? above_wr_ff : raw_ff.above_xm1;
      rd_data.cur_x     = fwd_ff[1] ? cur_wr_ff   : raw_ff.cur_x;
      rd_data.cur_xp1   = fwd_ff[0] ? cur_wr_ff   : raw_ff.cur_xp1;
   end

endmodule

/* hw/rtl/scgu_cell_rule.sv */
// update rule of one cell from its in-grid four-neighborhood and random draws
// depends on scgu_pkg
module scgu_cell_rule (
   input  scgu_pkg::nbr_type  nbr,
   input  scgu_pkg::rnd_type  rnd,
   output scgu_pkg::cell_type new_state
);

   logic               up_act, west_act, east_act, down_act;
   logic               any_active, any_inactive;
   logic               death_hit, spont_hit, spread_hit;
   scgu_pkg::cell_type spin;
   logic [scgu_pkg::DRAW_W:0] d1_inc, d2_inc;

   assign up_act   = nbr.up   != scgu_pkg::CELL_INACTIVE;
   assign west_act = nbr.west != scgu_pkg::CELL_INACTIVE;
   assign east_act = nbr.east != scgu_pkg::CELL_INACTIVE;
   assign down_act = nbr.down != scgu_pkg::CELL_INACTIVE;

   assign any_active   = (nbr.has_up && up_act) || (nbr.has_west && west_act)
                      || (nbr.has_east && east_act) || (nbr.has_down && down_act);
   assign any_inactive = (nbr.has_up && !up_act) || (nbr.has_west && !west_act)
                      || (nbr.has_east && !east_act) || (nbr.has_down && !down_act);

   // draw plus one below threshold
   assign d1_inc = {1'b0, rnd.draw_first}  + (scgu_pkg::DRAW_W+1)'(1);
   assign d2_inc = {1'b0, rnd.draw_second} + (scgu_pkg::DRAW_W+1)'(1);

   assign death_hit  = d1_inc < {1'b0, rnd.prob_death};
   assign spont_hit  = d1_inc < {1'b0, rnd.prob_spont};
   assign spread_hit = d2_inc < {1'b0, rnd.prob_spread};

   assign spin = rnd.spin_pick ? scgu_pkg::CELL_SPIN_B : scgu_pkg::CELL_SPIN_A;

   always_comb begin
      if (nbr.cur != scgu_pkg::CELL_INACTIVE) begin
         if (!any_inactive) begin
            new_state = spin;
         end else begin
            new_state = death_hit ? scgu_pkg::CELL_INACTIVE : spin;
         end
      end else if (spont_hit) begin
         new_state = spin;
      end else if (any_active && spread_hit) begin
         new_state = spin;
      end else begin
         new_state = scgu_pkg::CELL_INACTIVE;
      end
   end

endmodule

/* hw/rtl/stochastic_cell_grid_update.sv */
// a cell is worked when the beat below it leaves the input register; its result is registered
// throughput: one beat per cycle, unless stalled; a worked beat reads the next column's window
// after each csr write the block pauses while the line buffers re-read
// reset (synchronous, active high) clears counters and valid flags and loads the csr defaults;
// line buffer contents are not cleared, the first grid row fills them
module stochastic_cell_grid_update (
   input  logic                             clock,
   input  logic                             reset,
   // input beats
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cell_state[1:0], draw_first[15:2], draw_second[29:16], spin_pick[30], zero[31]
   input  logic [scgu_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type[0]
   input  logic                             req_tuser,
   // result beats
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cell_x[7:0], cell_y[19:8], new_state[21:20], zero[23:22]
   output logic [scgu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // frame_last
   output logic                             rsp_tlast,
   // configuration writes
   input  logic                             csr_we,
   input  logic [scgu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [scgu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // csr registers
   logic [scgu_pkg::FW_W-1:0]   frame_width_ff;
   logic [scgu_pkg::FH_W-1:0]   frame_height_ff;
   logic [scgu_pkg::PROB_W-1:0] prob_death_ff;
   logic [scgu_pkg::PROB_W-1:0] prob_spont_ff;
   logic [scgu_pkg::PROB_W-1:0] prob_spread_ff;
   logic                        refetch_ff;

   // input register
   logic                                 in_vld_ff;
   logic                                 in_kind_ff;
   logic [scgu_pkg::REQ_TDATA_W-1:0]     in_data_ff;

   // raster position of the incoming cell
   logic [scgu_pkg::COL_W-1:0] col_ff, col_in;
   logic [scgu_pkg::ROW_W-1:0] row_ff, row_in;

   // result register
   logic                       rsp_vld_ff, rsp_vld_in;
   logic [scgu_pkg::COL_W-1:0] rsp_x_ff;
   logic [scgu_pkg::Y_W-1:0]   rsp_y_ff;
   scgu_pkg::cell_type         rsp_state_ff;
   logic                       rsp_last_ff;

   // work stage
   logic [scgu_pkg::COL_W:0]   width_use;
   logic [scgu_pkg::COL_W-1:0] wm1;
   logic [scgu_pkg::FH_W-1:0]  height_use;
   logic [scgu_pkg::COL_W-1:0] x, x_next, col_step;
   logic                       last_col, pad_row, ignored;
   logic                       fire, upd, has_result;
   scgu_pkg::cell_type         cs, incoming, new_state;
   logic [scgu_pkg::COL_W-1:0] rd_addr;
   scgu_pkg::lb_rd_type        lb_rd;
   scgu_pkg::nbr_type          nbr;
   scgu_pkg::rnd_type          rnd;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= scgu_pkg::RST_FRAME_WIDTH;
         frame_height_ff <= scgu_pkg::RST_FRAME_HEIGHT;
         prob_death_ff   <= scgu_pkg::RST_PROB_DEATH;
         prob_spont_ff   <= scgu_pkg::RST_PROB_SPONT;
         prob_spread_ff  <= scgu_pkg::RST_PROB_SPREAD;
         refetch_ff      <= 1'b0;
      end else begin
         refetch_ff <= csr_we;
         if (csr_we) begin
            unique case (csr_index)
               scgu_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[scgu_pkg::FW_W-1:0];
               scgu_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[scgu_pkg::FH_W-1:0];
               scgu_pkg::CSR_PROB_DEATH:   prob_death_ff   <= csr_wdata;
               scgu_pkg::CSR_PROB_SPONT:   prob_spont_ff   <= csr_wdata;
               scgu_pkg::CSR_PROB_SPREAD:  prob_spread_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- frame size in use
   always_comb begin
      if (frame_width_ff < scgu_pkg::FW_W'(scgu_pkg::MIN_DIM)) begin
         width_use = (scgu_pkg::COL_W+1)'(scgu_pkg::MIN_DIM);
      end else if (frame_width_ff > scgu_pkg::FW_W'(scgu_pkg::MAX_WIDTH)) begin
         width_use = (scgu_pkg::COL_W+1)'(scgu_pkg::MAX_WIDTH);
      end else begin
         width_use = (scgu_pkg::COL_W+1)'(frame_width_ff);
      end
      if (frame_height_ff < scgu_pkg::FH_W'(scgu_pkg::MIN_DIM)) begin
         height_use = scgu_pkg::FH_W'(scgu_pkg::MIN_DIM);
      end else if (frame_height_ff > scgu_pkg::FH_W'(scgu_pkg::MAX_HEIGHT)) begin
         height_use = scgu_pkg::FH_W'(scgu_pkg::MAX_HEIGHT);
      end else begin
         height_use = frame_height_ff;
      end
   end

   assign wm1 = scgu_pkg::COL_W'(width_use - (scgu_pkg::COL_W+1)'(1));

   // ---------------------------------------------------------------- handshake
   // the work stage fires when the result slot is free or being emptied;
   // a refetch cycle after a csr write lets the line buffers follow a new width
   assign fire       = in_vld_ff && !refetch_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_vld_ff <= 1'b1;
      end else if (fire) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------- position and kind
   assign x        = (col_ff > wm1) ? wm1 : col_ff;
   assign last_col = (x == wm1);
   assign pad_row  = row_ff >= scgu_pkg::ROW_W'(height_use);

   // a pad beat in grid rows, or a grid beat in the pad row, is dropped
   assign ignored    = (in_kind_ff == scgu_pkg::REQ_PAD) != pad_row;
   assign upd        = fire && !ignored;
   assign has_result = upd && (row_ff != '0);

   assign cs       = in_data_ff[scgu_pkg::STATE_W-1:0];
   assign incoming = (pad_row || cs == scgu_pkg::CELL_BAD) ? scgu_pkg::CELL_INACTIVE : cs;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (upd) begin
         if (last_col) begin
            col_in = '0;
            row_in = pad_row ? '0 : row_ff + scgu_pkg::ROW_W'(1);
         end else begin
            col_in = x + scgu_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // read window for the cell of the next cycle
   assign col_step = last_col ? '0 : x + scgu_pkg::COL_W'(1);
   assign x_next   = (col_step > wm1) ? wm1 : col_step;
   assign rd_addr  = upd ? x_next : x;

   // ---------------------------------------------------------------- line buffers
   scgu_line_buf u_line_buf (
      .clock       (clock),
      .wr_en       (upd),
      .wr_addr     (x),
      .above_wdata (lb_rd.cur_x),
      .cur_wdata   (incoming),
      .rd_addr     (rd_addr),
      .rd_data     (lb_rd)
   );

   // ---------------------------------------------------------------- cell rule
   always_comb begin
      nbr.cur      = lb_rd.cur_x;
      nbr.up       = lb_rd.above_x;
      nbr.west     = lb_rd.above_xm1;
      nbr.east     = lb_rd.cur_xp1;
      nbr.down     = incoming;
      nbr.has_up   = row_ff > scgu_pkg::ROW_W'(1);
      nbr.has_west = x != '0;
      nbr.has_east = !last_col;
      nbr.has_down = !pad_row;
   end

   always_comb begin
      rnd.prob_death  = prob_death_ff;
      rnd.prob_spont  = prob_spont_ff;
      rnd.prob_spread = prob_spread_ff;
      rnd.draw_first  = in_data_ff[15:2];
      rnd.draw_second = in_data_ff[29:16];
      rnd.spin_pick   = in_data_ff[30];
   end

   scgu_cell_rule u_cell_rule (
      .nbr       (nbr),
      .rnd       (rnd),
      .new_state (new_state)
   );

   // ---------------------------------------------------------------- result register
   always_comb begin
      if (fire) begin
         rsp_vld_in = has_result;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (has_result) begin
         rsp_x_ff     <= x;
         rsp_y_ff     <= scgu_pkg::Y_W'(row_ff - scgu_pkg::ROW_W'(1));
         rsp_state_ff <= new_state;
         rsp_last_ff  <= pad_row && last_col;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_state_ff, rsp_y_ff, rsp_x_ff};

   // ---------------------------------------------------------------- checks
   // no cell is worked while the line buffers re-read after a csr write
   assert property (@(posedge clock) disable iff (reset) refetch_ff |-> !fire)
      else $error("work stage fired during refetch");

   // a dropped beat leaves the raster position alone
   assert property (@(posedge clock) disable iff (reset)
      (fire && ignored) |=> ($stable(col_ff) && $stable(row_ff)))
      else $error("dropped beat moved the raster position");

   // a worked cell with a row above always shows up at the result register
   assert property (@(posedge clock) disable iff (reset) has_result |=> rsp_vld_ff)
      else $error("result lost");

   // while the last cell of a frame waits, the counters already sit at frame start
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_last_ff) |-> (col_ff == '0 && row_ff == '0))
      else $error("frame end without counter wrap");

endmodule
